FILE: rtl/haet_pkg.sv
// ----------------------------------------------------------------------------
// haet_pkg
// Shared types and constants for the heap allocation event tracker.
// ----------------------------------------------------------------------------
package haet_pkg;

    localparam int LIVE_ENTRIES = 1024;
    localparam int ADDRESS_BITS = 48;
    localparam int IDX_W        = $clog2(LIVE_ENTRIES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int END_BITS     = ADDRESS_BITS + 1;
    localparam int SUM_W        = 65;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_REALLOC = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_ALLOC_OK       = 3'd0,
        ST_FREE_OK        = 3'd1,
        ST_ALLOC_CONFLICT = 3'd2,
        ST_FREE_CONFLICT  = 3'd3,
        ST_TABLE_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        kind_t                   kind;
        logic [ADDRESS_BITS-1:0] address;
        logic [ADDRESS_BITS-1:0] prior_address;
        logic [31:0]             alloc_size;
        logic [7:0]              heap_id;
    } item_t;

    typedef struct packed {
        logic [31:0]             tick;
        status_t                 status;
        logic [31:0]             block_index;
        logic [ADDRESS_BITS-1:0] event_address;
        logic [31:0]             event_size;
        logic [ADDRESS_BITS-1:0] low_address;
        logic [END_BITS-1:0]     high_address;
        logic                    last;
    } result_t;

    typedef struct packed {
        logic                    valid;
        logic [7:0]              heap;
        logic [ADDRESS_BITS-1:0] address;
        logic [31:0]             record;
    } entry_t;

    typedef enum logic [1:0] {
        S_CLEAR  = 2'd0,
        S_IDLE   = 2'd1,
        S_SCAN   = 2'd2,
        S_COMMIT = 2'd3
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic scan_start;
        logic scan_step;
        logic commit;
        logic alloc_phase;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic scan_done;
    } sts_t;

endpackage

FILE: rtl/haet_ctrl.sv
// ----------------------------------------------------------------------------
// haet_ctrl
// Sequencer: table clear after reset, then per step a table walk and a commit.
// ----------------------------------------------------------------------------
module haet_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  haet_pkg::kind_t kind,
    input  haet_pkg::sts_t sts,
    output haet_pkg::cmd_t cmd,
    output logic           busy
);
    import haet_pkg::*;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;
    logic   realloc_reg, realloc_next;

    // state and phase registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            phase_reg   <= 1'b0;
            realloc_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            realloc_reg <= realloc_next;
        end
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        realloc_next = realloc_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start && kind != KIND_NONE)
                begin
                    state_next   = S_SCAN;
                    phase_next   = (kind == KIND_ALLOC);
                    realloc_next = (kind == KIND_REALLOC);
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (realloc_reg && !phase_reg)
                begin
                    state_next = S_SCAN;
                    phase_next = 1'b1;
                end
                else
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd             = '0;
        cmd.alloc_phase = phase_reg;
        cmd.last        = !(realloc_reg && !phase_reg);
        busy            = (state_reg != S_IDLE);
        unique case (state_reg)
            S_CLEAR:  cmd.clear_wr = 1'b1;
            S_IDLE:
            begin
                if (start && kind != KIND_NONE)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                end
            end
            S_SCAN:   cmd.scan_step = 1'b1;
            S_COMMIT:
            begin
                cmd.commit     = 1'b1;
                cmd.scan_start = realloc_reg && !phase_reg;
            end
            default:  cmd = '0;
        endcase
    end

endmodule

FILE: rtl/haet_dp.sv
// ----------------------------------------------------------------------------
// haet_dp
// Datapath: live table memory, walk counter, match/slot finder, counters,
// address bounds and the result register.
// ----------------------------------------------------------------------------
module haet_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  haet_pkg::item_t   item,
    input  haet_pkg::cmd_t    cmd,
    output haet_pkg::sts_t    sts,
    output haet_pkg::result_t result,
    output logic              result_valid
);
    import haet_pkg::*;

    entry_t mem [LIVE_ENTRIES];

    item_t                   item_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic                    rd_pend_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    entry_t                  rd_data_reg;
    logic                    hit_reg;
    logic [IDX_W-1:0]        hit_idx_reg;
    logic [31:0]             hit_rec_reg;
    logic                    slot_found_reg;
    logic [IDX_W-1:0]        slot_idx_reg;
    logic [31:0]             tick_reg;
    logic [31:0]             record_count_reg, record_count_next;
    logic [ADDRESS_BITS-1:0] low_reg, low_next;
    logic [END_BITS-1:0]     high_reg, high_next;
    result_t                 result_reg, result_next;
    logic                    result_valid_reg;

    logic                    walk_end;
    logic                    rd_en;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    entry_t                  wr_data;
    logic [ADDRESS_BITS-1:0] key_addr;
    logic                    match;
    logic [SUM_W-1:0]        end_sum;
    logic [END_BITS-1:0]     end_addr;

    assign walk_end = (idx_reg == CNT_W'(LIVE_ENTRIES));
    assign rd_en    = cmd.scan_step && !walk_end;
    assign sts.clear_done = walk_end;
    assign sts.scan_done  = walk_end && !rd_pend_reg;

    // key of the current step
    assign key_addr = (!cmd.alloc_phase && item_reg.kind == KIND_REALLOC)
                      ? item_reg.prior_address : item_reg.address;
    assign match = rd_data_reg.valid && rd_data_reg.address == key_addr
                   && rd_data_reg.heap == item_reg.heap_id;

    // block end, saturating only on a full-width carry
    assign end_sum  = SUM_W'(item_reg.address) + SUM_W'(item_reg.alloc_size);
    assign end_addr = end_sum[SUM_W-1] ? '1 : end_sum[END_BITS-1:0];

    // commit decision and table write
    always_comb
    begin
        result_next       = result_reg;
        record_count_next = record_count_reg;
        low_next          = low_reg;
        high_next         = high_reg;
        wr_en             = 1'b0;
        wr_addr           = idx_reg[IDX_W-1:0];
        wr_data           = '0;
        if (cmd.clear_wr && !walk_end)
            wr_en = 1'b1;
        if (cmd.commit)
        begin
            result_next.tick          = tick_reg + 32'd1;
            result_next.event_address = key_addr;
            result_next.event_size    = '0;
            result_next.block_index   = '0;
            result_next.last          = cmd.last;
            if (!cmd.alloc_phase)
            begin
                if (hit_reg)
                begin
                    result_next.status      = ST_FREE_OK;
                    result_next.block_index = hit_rec_reg;
                    wr_en   = 1'b1;
                    wr_addr = hit_idx_reg;
                end
                else
                    result_next.status = ST_FREE_CONFLICT;
            end
            else if (hit_reg)
                result_next.status = ST_ALLOC_CONFLICT;
            else if (!slot_found_reg)
                result_next.status = ST_TABLE_FULL;
            else
            begin
                result_next.status      = ST_ALLOC_OK;
                result_next.block_index = record_count_reg;
                result_next.event_size  = item_reg.alloc_size;
                record_count_next       = record_count_reg + 32'd1;
                wr_en           = 1'b1;
                wr_addr         = slot_idx_reg;
                wr_data.valid   = 1'b1;
                wr_data.heap    = item_reg.heap_id;
                wr_data.address = item_reg.address;
                wr_data.record  = record_count_reg;
                if (end_addr > high_reg)
                    high_next = end_addr;
                if (item_reg.address < low_reg)
                    low_next = item_reg.address;
            end
            result_next.low_address  = low_next;
            result_next.high_address = high_next;
        end
    end

    // live table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
        if (rd_en)
            rd_idx_reg <= idx_reg[IDX_W-1:0];
        result_reg <= result_next;
    end

    // walk control, finder and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg          <= '0;
            rd_pend_reg      <= 1'b0;
            hit_reg          <= 1'b0;
            hit_idx_reg      <= '0;
            hit_rec_reg      <= '0;
            slot_found_reg   <= 1'b0;
            slot_idx_reg     <= '0;
            tick_reg         <= '0;
            record_count_reg <= '0;
            low_reg          <= '1;
            high_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.commit;
            record_count_reg <= record_count_next;
            low_reg          <= low_next;
            high_reg         <= high_next;
            if (cmd.commit)
                tick_reg <= tick_reg + 32'd1;
            if (cmd.clear_wr && !walk_end)
                idx_reg <= idx_reg + CNT_W'(1);
            if (cmd.scan_start)
            begin
                idx_reg        <= '0;
                rd_pend_reg    <= 1'b0;
                hit_reg        <= 1'b0;
                slot_found_reg <= 1'b0;
            end
            else
            begin
                rd_pend_reg <= rd_en;
                if (rd_en)
                    idx_reg <= idx_reg + CNT_W'(1);
                if (rd_pend_reg && match)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= rd_idx_reg;
                    hit_rec_reg <= rd_data_reg.record;
                end
                if (rd_pend_reg && !rd_data_reg.valid && !slot_found_reg)
                begin
                    slot_found_reg <= 1'b1;
                    slot_idx_reg   <= rd_idx_reg;
                end
            end
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // checks
    a_commit_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> walk_end && !rd_pend_reg)
        else $error("commit before walk finished");
    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $past(cmd.commit))
        else $error("result without commit");
    a_record_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        record_count_reg != $past(record_count_reg) |->
            result_valid_reg && result_reg.status == ST_ALLOC_OK)
        else $error("record count moved without a recorded alloc");

endmodule

FILE: rtl/heap_allocation_event_tracker_top.sv
// An alloc or free walks the whole live table (S_SCAN) and then commits (S_COMMIT);
// the result strobe is registered from the commit. A realloc runs a free of the
// prior address and then an alloc, each with its own result. A new item is taken
// only when idle, once the previous commit is done; the walk reads one entry per cycle.
// After reset busy stays high while the table is cleared.
// Results appear for one cycle on result_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
// heap_allocation_event_tracker_top
// Tracks live heap blocks per heap, reports conflicts, record indices, bounds.
// ----------------------------------------------------------------------------
module heap_allocation_event_tracker_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  haet_pkg::item_t   item,
    output haet_pkg::result_t result,
    output logic              result_valid
);
    import haet_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    haet_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (item.kind),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // table and result datapath
    haet_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
